@@ rtl/core/sssp_pkg.sv @@
// shared constants, types and codes of the shortest path unit
`default_nettype none
package sssp_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 1024;

	localparam int NODE_W   = 7;
	localparam int IDX_W    = $clog2(MAX_NODES);
	localparam int WEIGHT_W = 32;
	localparam int DIST_W   = 48;
	localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EDGE_CW  = $clog2(MAX_EDGES + 1);

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_NODE = 2'd1;

	typedef logic [0:0] alu_op_t;
	localparam alu_op_t ALU_CMP     = 1'b0;
	localparam alu_op_t ALU_ADD_CMP = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0] node_count;
		logic [NODE_W-1:0] source_node;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]    start_node;
		logic [IDX_W-1:0]    end_node;
		logic [WEIGHT_W-1:0] length;
	} edge_entry_t;

	typedef struct packed {
		logic        en;
		edge_entry_t entry;
	} edge_wr_t;

	typedef struct packed {
		logic               en;
		logic [EDGE_AW-1:0] addr;
		logic               clear;
	} edge_rd_t;

endpackage
`default_nettype wire

@@ rtl/core/sssp_edge_if.sv @@
// edge input channel of the shortest path unit
`default_nettype none
interface sssp_edge_if;
	import sssp_pkg::*;

	logic                valid;
	logic                ready;
	logic                has_edge;
	logic [NODE_W-1:0]   from_node;
	logic [NODE_W-1:0]   to_node;
	logic [WEIGHT_W-1:0] weight;
	logic                last_edge;

	modport source (output valid, has_edge, from_node, to_node, weight, last_edge,
		input ready);
	modport sink (input valid, has_edge, from_node, to_node, weight, last_edge,
		output ready);
endinterface
`default_nettype wire

@@ rtl/core/sssp_result_if.sv @@
// result output channel of the shortest path unit
`default_nettype none
interface sssp_result_if;
	import sssp_pkg::*;

	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node;
	logic [DIST_W-1:0] distance;
	logic              reachable;
	logic              last_result;

	modport source (output valid, node, distance, reachable, last_result, input ready);
	modport sink (input valid, node, distance, reachable, last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sssp_alu.sv @@
// shared saturating adder and magnitude comparator
`default_nettype none
module sssp_alu (
	input  sssp_pkg::alu_op_t             op,
	input  logic [sssp_pkg::DIST_W-1:0]   a,
	input  logic [sssp_pkg::DIST_W-1:0]   b,
	input  logic [sssp_pkg::DIST_W-1:0]   c,
	output logic [sssp_pkg::DIST_W-1:0]   sum,
	output logic                          less
);
	import sssp_pkg::*;

	logic [DIST_W:0] wide_sum;

	always_comb begin
		wide_sum = {1'b0, a} + {1'b0, b};
		sum      = wide_sum[DIST_W] ? DIST_MAX : wide_sum[DIST_W-1:0];
		case (op)
			ALU_CMP:     less = a < b;
			ALU_ADD_CMP: less = sum < c;
			default:     less = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/sssp_edge_store.sv @@
// edge table memory and fill count
`default_nettype none
module sssp_edge_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sssp_pkg::edge_wr_t             wr,
	input  sssp_pkg::edge_rd_t             rd,
	output sssp_pkg::edge_entry_t          rd_data,
	output logic [sssp_pkg::EDGE_CW-1:0]   count
);
	import sssp_pkg::*;

	edge_entry_t        edge_mem [MAX_EDGES];
	logic [EDGE_CW-1:0] count_q;
	logic               wr_ok;

	assign wr_ok = wr.en && (count_q < EDGE_CW'(MAX_EDGES));
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (rd.clear) begin
			count_q <= '0;
		end else if (wr_ok) begin
			count_q <= count_q + EDGE_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			edge_mem[count_q[EDGE_AW-1:0]] <= wr.entry;
		end
		if (rd.en) begin
			rd_data <= edge_mem[rd.addr];
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EDGE_CW'(MAX_EDGES))
		else $error("edge count beyond table depth");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rd.clear |=> count_q == '0)
		else $error("edge table not emptied after run");
	a_read_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> (EDGE_CW'(rd.addr) < count_q))
		else $error("edge table read beyond stored edges");
`endif
endmodule
`default_nettype wire

@@ rtl/core/sssp_engine.sv @@
// search sequencer with distance store, settled marks and result register
`default_nettype none
module sssp_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sssp_pkg::cfg_t                 cfg,
	sssp_edge_if.sink                      edges,
	sssp_result_if.source                  results,
	output sssp_pkg::edge_wr_t             edge_wr,
	output sssp_pkg::edge_rd_t             edge_rd,
	input  sssp_pkg::edge_entry_t          edge_data,
	input  logic [sssp_pkg::EDGE_CW-1:0]   edge_count
);
	import sssp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_E_RD  = 3'd3;
	localparam logic [2:0] ST_E_CHK = 3'd4;
	localparam logic [2:0] ST_E_UPD = 3'd5;
	localparam logic [2:0] ST_O_RD  = 3'd6;
	localparam logic [2:0] ST_O_WR  = 3'd7;

	logic [2:0]           state_q;
	logic [NODE_W-1:0]    n_q;
	logic [NODE_W-1:0]    scan_k_q;
	logic [IDX_W-1:0]     out_k_q;
	logic [IDX_W-1:0]     ri_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 rv_q;
	logic                 found_q;
	logic [DIST_W-1:0]    low_q;
	logic [DIST_W-1:0]    dist_rd_q;
	logic [EDGE_CW-1:0]   e_q;
	logic [MAX_NODES-1:0] settled_q;
	logic [MAX_NODES-1:0] reached_q;
	logic                 out_valid_q;
	logic [NODE_W-1:0]    out_node_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic                 out_reach_q;
	logic                 out_last_q;

	logic [DIST_W-1:0] dist_mem [MAX_NODES];

	logic              in_xfer;
	logic              from_ok;
	logic              to_ok;
	logic [NODE_W-1:0] n_clamp;
	logic              src_ok;
	logic [IDX_W-1:0]  src_idx;
	logic              scan_rd;
	logic              scan_take;
	logic              scan_done;
	logic              relax_ok;
	logic              out_load;
	logic              out_last;
	logic              dist_re;
	logic [IDX_W-1:0]  dist_ra;
	logic              dist_we;
	logic [IDX_W-1:0]  dist_wa;
	logic [DIST_W-1:0] dist_wd;
	logic [IDX_W-1:0]  cand_idx;
	logic [DIST_W-1:0] cand;
	alu_op_t           alu_op;
	logic [DIST_W-1:0] alu_a;
	logic [DIST_W-1:0] alu_b;
	logic [DIST_W-1:0] alu_sum;
	logic              alu_less;

	assign edges.ready = (state_q == ST_IDLE);
	assign in_xfer     = edges.valid && edges.ready;

	assign from_ok = (edges.from_node != '0) && (edges.from_node <= NODE_W'(MAX_NODES));
	assign to_ok   = (edges.to_node != '0) && (edges.to_node <= NODE_W'(MAX_NODES));

	assign edge_wr.en               = in_xfer && edges.has_edge && from_ok && to_ok;
	assign edge_wr.entry.start_node = IDX_W'(edges.from_node - NODE_W'(1));
	assign edge_wr.entry.end_node   = IDX_W'(edges.to_node - NODE_W'(1));
	assign edge_wr.entry.length     = edges.weight;

	always_comb begin
		if (cfg.node_count == '0) begin
			n_clamp = NODE_W'(1);
		end else if (cfg.node_count > NODE_W'(MAX_NODES)) begin
			n_clamp = NODE_W'(MAX_NODES);
		end else begin
			n_clamp = cfg.node_count;
		end
	end

	assign src_ok  = (cfg.source_node != '0) && (cfg.source_node <= n_q);
	assign src_idx = IDX_W'(cfg.source_node - NODE_W'(1));

	assign scan_rd   = (state_q == ST_SCAN) && (scan_k_q < n_q);
	assign scan_done = (scan_k_q == n_q) && !rv_q;
	assign scan_take = (state_q == ST_SCAN) && rv_q && !settled_q[ri_q] && alu_less;
	assign relax_ok  = (edge_data.start_node == pick_q) &&
		(NODE_W'(edge_data.end_node) < n_q);
	assign out_load  = (state_q == ST_O_WR) && (!out_valid_q || results.ready);
	assign out_last  = (NODE_W'(out_k_q) + NODE_W'(1)) == n_q;

	assign edge_rd.en    = (state_q == ST_E_RD) && (e_q < edge_count);
	assign edge_rd.addr  = e_q[EDGE_AW-1:0];
	assign edge_rd.clear = out_load && out_last;

	always_comb begin
		dist_re = 1'b0;
		dist_ra = scan_k_q[IDX_W-1:0];
		dist_we = 1'b0;
		dist_wa = src_idx;
		dist_wd = '0;
		case (state_q)
			ST_INIT: begin
				dist_we = src_ok;
			end
			ST_SCAN: begin
				dist_re = scan_rd;
			end
			ST_E_CHK: begin
				dist_re = relax_ok;
				dist_ra = edge_data.end_node;
			end
			ST_E_UPD: begin
				dist_we = alu_less;
				dist_wa = edge_data.end_node;
				dist_wd = alu_sum;
			end
			ST_O_RD: begin
				dist_re = 1'b1;
				dist_ra = out_k_q;
			end
			default: begin
				dist_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_E_UPD: cand_idx = edge_data.end_node;
			ST_O_WR:  cand_idx = out_k_q;
			default:  cand_idx = ri_q;
		endcase
		cand = reached_q[cand_idx] ? dist_rd_q : DIST_MAX;
		if (state_q == ST_E_UPD) begin
			alu_op = ALU_ADD_CMP;
			alu_a  = low_q;
			alu_b  = DIST_W'(edge_data.length);
		end else begin
			alu_op = ALU_CMP;
			alu_a  = cand;
			alu_b  = low_q;
		end
	end

	sssp_alu u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.c    (cand),
		.sum  (alu_sum),
		.less (alu_less)
	);

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		if (dist_re) begin
			dist_rd_q <= dist_mem[dist_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= NODE_W'(1);
			scan_k_q    <= '0;
			out_k_q     <= '0;
			rv_q        <= 1'b0;
			found_q     <= 1'b0;
			e_q         <= '0;
			settled_q   <= '0;
			reached_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && edges.last_edge) begin
						n_q       <= n_clamp;
						settled_q <= '0;
						reached_q <= '0;
						state_q   <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (src_ok) begin
						reached_q[src_idx] <= 1'b1;
					end
					scan_k_q <= '0;
					rv_q     <= 1'b0;
					found_q  <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					rv_q <= scan_rd;
					if (scan_rd) begin
						scan_k_q <= scan_k_q + NODE_W'(1);
					end
					if (scan_take) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						if (found_q) begin
							settled_q[pick_q] <= 1'b1;
							e_q               <= '0;
							state_q           <= ST_E_RD;
						end else begin
							out_k_q <= '0;
							state_q <= ST_O_RD;
						end
					end
				end
				ST_E_RD: begin
					if (edge_rd.en) begin
						state_q <= ST_E_CHK;
					end else begin
						scan_k_q <= '0;
						rv_q     <= 1'b0;
						found_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_E_CHK: begin
					if (relax_ok) begin
						state_q <= ST_E_UPD;
					end else begin
						e_q     <= e_q + EDGE_CW'(1);
						state_q <= ST_E_RD;
					end
				end
				ST_E_UPD: begin
					if (alu_less) begin
						reached_q[edge_data.end_node] <= 1'b1;
					end
					e_q     <= e_q + EDGE_CW'(1);
					state_q <= ST_E_RD;
				end
				ST_O_RD: begin
					state_q <= ST_O_WR;
				end
				ST_O_WR: begin
					if (out_load) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							out_k_q <= out_k_q + IDX_W'(1);
							state_q <= ST_O_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			ri_q <= scan_k_q[IDX_W-1:0];
		end
		if ((state_q == ST_INIT) || ((state_q == ST_E_RD) && !edge_rd.en)) begin
			low_q <= DIST_MAX;
		end else if (scan_take) begin
			low_q  <= cand;
			pick_q <= ri_q;
		end
		if (out_load) begin
			out_node_q  <= NODE_W'(out_k_q) + NODE_W'(1);
			out_dist_q  <= reached_q[out_k_q] ? dist_rd_q : '0;
			out_reach_q <= reached_q[out_k_q];
			out_last_q  <= out_last;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.node        = out_node_q;
	assign results.distance    = out_dist_q;
	assign results.reachable   = out_reach_q;
	assign results.last_result = out_last_q;

`ifndef NO_ASSERTIONS
	a_settled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(settled_q) <= int'(n_q))
		else $error("more nodes settled than in use");
	a_pick_open: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && found_q) |-> (!settled_q[pick_q] && reached_q[pick_q]))
		else $error("picked node already settled or unreached");
	a_relax_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_UPD) |-> (edge_data.start_node == pick_q))
		else $error("relaxing an edge that does not leave the picked node");
`endif
endmodule
`default_nettype wire

@@ rtl/core/single_source_shortest_path_unit.sv @@
// top level of the single source shortest path unit
// usage:
//  - edges: one directed weighted edge per transfer, taken one per cycle while idle;
//    has_edge low makes a bare trigger, edges with a node outside 1..64 or beyond
//    the 1024-entry table are dropped
//  - a transfer with last_edge high starts the search from source_node over nodes
//    1..node_count; edges.ready stays low until the last result is in the output register
//  - search: seeds the source, then per settled node one scan of the nodes in use
//    over the distance store, then a pass over every stored edge with an update for
//    each edge from that node to a node in use; one final scan finds nothing left and
//    ends the search
//  - results: one transfer per node in ascending order; last_result marks the final
//    node, unreachable nodes show reachable low and distance zero
//  - a stalled sink holds the result register and the sequencer waits on it
//  - cfg_we/cfg_index/cfg_data write node_count (index 0) and source_node (index 1);
//    the user must write only while idle, the block does not enforce it; other indexes are ignored
//  - arst_n clears the edge table, settled and reached marks, sets node_count to 64
//    and source_node to 1; no clearing pass is needed
`default_nettype none
module single_source_shortest_path_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sssp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sssp_pkg::CFG_DATA_W-1:0]     cfg_data,
	sssp_edge_if.sink                           edges,
	sssp_result_if.source                       results
);
	import sssp_pkg::*;

	logic [NODE_W-1:0]  node_count_q;
	logic [NODE_W-1:0]  source_node_q;
	cfg_t               cfg;
	edge_wr_t           edge_wr;
	edge_rd_t           edge_rd;
	edge_entry_t        edge_data;
	logic [EDGE_CW-1:0] edge_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_W'(MAX_NODES);
			source_node_q <= NODE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT:  node_count_q  <= NODE_W'(cfg_data);
				REG_SOURCE_NODE: source_node_q <= NODE_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg.node_count  = node_count_q;
	assign cfg.source_node = source_node_q;

	sssp_edge_store u_edge_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (edge_wr),
		.rd      (edge_rd),
		.rd_data (edge_data),
		.count   (edge_count)
	);

	sssp_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.edges      (edges),
		.results    (results),
		.edge_wr    (edge_wr),
		.edge_rd    (edge_rd),
		.edge_data  (edge_data),
		.edge_count (edge_count)
	);
endmodule
`default_nettype wire
